/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SKVF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SKVF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/skvf_pkg.sv */
// Package of widths, reset values, codes and types for the velocity Kalman filter.
package skvf_pkg;

    // Field and fixed-point widths.
    localparam int DATA_W    = 24;
    localparam int FRAC_BITS = 16;
    localparam int K_W       = FRAC_BITS + 1;      // gain, 0 .. 1.0 inclusive
    localparam int DEN_W     = DATA_W + 1;         // p + R
    localparam int REM_W     = DEN_W + 1;          // divider remainder after shift
    localparam int DIFF_W    = DATA_W + 1;         // z - estimate
    localparam int STEP_W    = REM_W + 1;          // floor(k * diff / 2^FRAC_BITS)
    localparam int ESUM_W    = STEP_W + 1;
    localparam int TDATA_W   = 2 * DATA_W;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = $clog2(K_W + 1);

    // Fixed-point constants, worked out at elaboration.
    localparam longint ONE_L     = longint'(1) << FRAC_BITS;
    localparam longint U_MAX_L   = (longint'(1) << DATA_W) - 1;
    localparam longint S_MAX_L   = (longint'(1) << (DATA_W - 1)) - 1;
    localparam longint Q_RST_L   = (ONE_L + 50) / 100;
    localparam longint R_RST_L   = (3 * ONE_L + 5) / 10;

    localparam logic [K_W-1:0]    K_ONE     = K_W'(ONE_L);
    localparam logic [DATA_W-1:0] Q_RESET   = DATA_W'((Q_RST_L > U_MAX_L) ? U_MAX_L : Q_RST_L);
    localparam logic [DATA_W-1:0] R_RESET   = DATA_W'((R_RST_L > U_MAX_L) ? U_MAX_L : R_RST_L);
    localparam logic [DATA_W-1:0] EST_RESET = DATA_W'((ONE_L > S_MAX_L) ? S_MAX_L : ONE_L);
    localparam logic [DATA_W-1:0] VAR_RESET = Q_RESET;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREDICT,
        ST_SETUP,
        ST_DIVIDE,
        ST_MUL_SETUP,
        ST_MULTIPLY,
        ST_FINISH
    } fsm_state_t;

endpackage

/* rtl/scalar_kalman_velocity_filter.sv */
// An accepted input beat passes through the states PREDICT, SETUP, DIVIDE,
// MUL_SETUP, MULTIPLY and FINISH in order; a new beat is taken only back in IDLE.
// The bit-serial restoring divider and the shift-and-add multipliers do the bulk
// of the work; a held output stalls only the FINISH state.
// Reset: asynchronous, active low; estimate 1.0, variance and noise registers
// take their power-on values, no result is pending.
module scalar_kalman_velocity_filter
    import skvf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [23:0] velocity_in, [47:24] curvature_in
    // Output stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [23:0] velocity_out, [47:24] curvature_out
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    fsm_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_load;

    logic [DATA_W-1:0]        q_noise_reg;
    logic [DATA_W-1:0]        r_noise_reg;
    logic signed [DATA_W-1:0] est_reg;
    logic [DATA_W-1:0]        var_reg;

    logic signed [DATA_W-1:0] z_reg;
    logic [DATA_W-1:0]        curv_reg;
    logic [DATA_W-1:0]        p_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [FRAC_BITS-1:0]     quo_reg;
    logic [K_W-1:0]           kb_reg;
    logic [K_W-1:0]           mb_reg;
    logic signed [REM_W-1:0]  eacc_hi_reg;
    logic [K_W-1:0]           eacc_lo_reg;
    logic [DEN_W-1:0]         vacc_hi_reg;
    logic [K_W-1:0]           vacc_lo_reg;
    logic [TDATA_W-1:0]       m_tdata_reg;

    logic [DEN_W-1:0]         p_sum;
    logic [DATA_W-1:0]        p_sat;
    logic signed [DIFF_W-1:0] diff_val;
    logic [REM_W-1:0]         rem_sh;
    logic [REM_W-1:0]         den_ext;
    logic                     div_ge;
    logic [K_W-1:0]           k_val;
    logic signed [REM_W-1:0]  e_sum;
    logic [DEN_W-1:0]         v_sum;
    logic signed [STEP_W-1:0] step_val;
    logic signed [ESUM_W-1:0] est_sum;
    logic signed [DATA_W-1:0] est_sat;
    logic [REM_W-1:0]         var_prod;
    logic [DATA_W-1:0]        var_new;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Predict: variance plus process noise, saturated at the unsigned maximum.
    assign p_sum = {1'b0, var_reg} + {1'b0, q_noise_reg};
    assign p_sat = p_sum[DEN_W-1] ? {DATA_W{1'b1}} : p_sum[DATA_W-1:0];
    assign diff_val = DIFF_W'(z_reg) - DIFF_W'(est_reg);

    // One restoring division step per cycle.
    assign rem_sh  = {rem_reg[REM_W-2:0], 1'b0};
    assign den_ext = {1'b0, den_reg};
    assign div_ge  = (rem_sh >= den_ext);

    // With no measurement noise the gain is exactly one, or zero when p is zero too.
    always_comb
    begin
        if (r_noise_reg == '0)
        begin
            k_val = (p_reg != '0) ? K_ONE : '0;
        end
        else
        begin
            k_val = {1'b0, quo_reg};
        end
    end

    // Shift-and-add multiply steps: k * diff (signed) and (1 - k) * p (unsigned).
    assign e_sum = eacc_hi_reg + (kb_reg[0] ? REM_W'(diff_reg) : '0);
    assign v_sum = vacc_hi_reg + (mb_reg[0] ? {1'b0, p_reg} : '0);

    // Results of the multiplies, shifted down by the fraction bits.
    assign step_val = {eacc_hi_reg, eacc_lo_reg[K_W-1:FRAC_BITS]};
    assign est_sum  = ESUM_W'(est_reg) + ESUM_W'(step_val);
    assign var_prod = {vacc_hi_reg, vacc_lo_reg[K_W-1:FRAC_BITS]};

    // Saturate the new estimate and clamp the new variance.
    always_comb
    begin
        if (est_sum > ESUM_W'(signed'(S_MAX_L)))
        begin
            est_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (est_sum < -ESUM_W'(signed'(S_MAX_L)) - ESUM_W'(1))
        begin
            est_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            est_sat = est_sum[DATA_W-1:0];
        end
        var_new = (|var_prod[REM_W-1:DATA_W]) ? {DATA_W{1'b1}} : var_prod[DATA_W-1:0];
    end

    // Sequencer: next state, step counter and output valid.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        out_load      = 1'b0;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PREDICT;
                end
            end
            ST_PREDICT:
            begin
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cnt_next   = CNT_W'(FRAC_BITS);
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_MUL_SETUP;
                end
            end
            ST_MUL_SETUP:
            begin
                cnt_next   = CNT_W'(K_W);
                state_next = ST_MULTIPLY;
            end
            ST_MULTIPLY:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration registers and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            q_noise_reg  <= Q_RESET;
            r_noise_reg  <= R_RESET;
            est_reg      <= EST_RESET;
            var_reg      <= VAR_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE:     q_noise_reg <= cfg_data;
                    CFG_MEASUREMENT_NOISE: r_noise_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (out_load)
            begin
                est_reg <= est_sat;
                var_reg <= var_new;
            end
        end
    end

    // Datapath registers for the item in flight.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            z_reg    <= s_tdata[DATA_W-1:0];
            curv_reg <= s_tdata[TDATA_W-1:DATA_W];
        end
        if (state_reg == ST_PREDICT)
        begin
            p_reg    <= p_sat;
            diff_reg <= diff_val;
        end
        if (state_reg == ST_SETUP)
        begin
            den_reg <= {1'b0, p_reg} + {1'b0, r_noise_reg};
            rem_reg <= REM_W'(p_reg);
        end
        if (state_reg == ST_DIVIDE)
        begin
            rem_reg <= div_ge ? (rem_sh - den_ext) : rem_sh;
            quo_reg <= {quo_reg[FRAC_BITS-2:0], div_ge};
        end
        if (state_reg == ST_MUL_SETUP)
        begin
            kb_reg      <= k_val;
            mb_reg      <= K_ONE - k_val;
            eacc_hi_reg <= '0;
            eacc_lo_reg <= '0;
            vacc_hi_reg <= '0;
            vacc_lo_reg <= '0;
        end
        if (state_reg == ST_MULTIPLY)
        begin
            eacc_hi_reg <= {e_sum[REM_W-1], e_sum[REM_W-1:1]};
            eacc_lo_reg <= {e_sum[0], eacc_lo_reg[K_W-1:1]};
            vacc_hi_reg <= {1'b0, v_sum[DEN_W-1:1]};
            vacc_lo_reg <= {v_sum[0], vacc_lo_reg[K_W-1:1]};
            kb_reg      <= {1'b0, kb_reg[K_W-1:1]};
            mb_reg      <= {1'b0, mb_reg[K_W-1:1]};
        end
        if (out_load)
        begin
            m_tdata_reg <= {curv_reg, est_sat};
        end
    end

endmodule

/* rtl/skvf_checker.sv */
// Port-level checker for the velocity Kalman filter, bound to the top level.
`include "assert_macros.svh"

module skvf_checker
    import skvf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // The filter works on one beat at a time: no second beat right after one.
    `SKVF_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // A result appears only at the end of a run, never while input is open.
    `SKVF_ASSERT_IMP(a_result_after_work, $rose(m_tvalid), !$past(s_tready))

    // A stalled result beat holds its data.
    `SKVF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind scalar_kalman_velocity_filter skvf_checker u_skvf_checker (.*);

/* sim/skvf_result_checker.sv */
// Checker for the velocity Kalman filter: it predicts every output beat and compares it.
module skvf_result_checker
    import skvf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [23:0] velocity_in, [47:24] curvature_in
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [TDATA_W-1:0]   m_tdata,   // [23:0] velocity_out, [47:24] curvature_out
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending_results,
    output int                   results_checked
);

    // One output beat; the velocity sits in the low bits, as on the bus.
    typedef struct packed {
        logic [DATA_W-1:0] curvature;
        logic [DATA_W-1:0] velocity;
    } filtered_beat_t;

    // The checker's own copy of the filter state and noise registers.
    logic [DATA_W-1:0]        q_noise;
    logic [DATA_W-1:0]        r_noise;
    logic [DATA_W-1:0]        var_est;
    logic signed [DATA_W-1:0] vel_est;
    filtered_beat_t           filtered_q[$];

    // Predict and update for one measurement, then queue the filtered beat.
    task automatic kalman_update(input logic signed [DATA_W-1:0] z,
                                 input logic [DATA_W-1:0] curv);
        longint         p;
        longint         denom;
        longint         gain;
        longint         diff;
        longint         est_next;
        longint         var_next;
        filtered_beat_t beat;
        p = longint'(var_est) + longint'(q_noise);
        if (p > U_MAX_L)
            p = U_MAX_L;
        denom = p + longint'(r_noise);
        // With no noise at all the gain is taken as zero.
        gain = (denom != 0) ? (p << FRAC_BITS) / denom : longint'(0);
        diff = longint'(z) - longint'(vel_est);
        est_next = longint'(vel_est) + ((gain * diff) >>> FRAC_BITS);
        if (est_next > S_MAX_L)
            est_next = S_MAX_L;
        else if (est_next < -S_MAX_L - 1)
            est_next = -S_MAX_L - 1;
        var_next = ((ONE_L - gain) * p) >> FRAC_BITS;
        if (var_next > U_MAX_L)
            var_next = U_MAX_L;
        vel_est = DATA_W'(est_next);
        var_est = DATA_W'(var_next);
        beat.velocity  = vel_est;
        beat.curvature = curv;
        filtered_q.push_back(beat);
    endtask

    // Watch the three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        filtered_beat_t got;
        filtered_beat_t want;
        if (!rst_n)
        begin
            q_noise = Q_RESET;
            r_noise = R_RESET;
            var_est = VAR_RESET;
            vel_est = EST_RESET;
            filtered_q.delete();
            fail_count      = 0;
            pending_results = 0;
            results_checked = 0;
        end
        else
        begin
            // Indexes beyond the two registers are dropped by the block.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PROCESS_NOISE)
                    q_noise = cfg_data;
                else if (cfg_index == CFG_MEASUREMENT_NOISE)
                    r_noise = cfg_data;
            end

            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (filtered_q.size() == 0)
                begin
                    $error("output beat with nothing outstanding: velocity %0d, curvature %0d",
                           $signed(got.velocity), $signed(got.curvature));
                    fail_count++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    results_checked++;
                    if (got.velocity !== want.velocity)
                    begin
                        $error("velocity_out: expected %0d, actual %0d",
                               $signed(want.velocity), $signed(got.velocity));
                        fail_count++;
                    end
                    if (got.curvature !== want.curvature)
                    begin
                        $error("curvature_out: expected %0d, actual %0d",
                               $signed(want.curvature), $signed(got.curvature));
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                kalman_update(s_tdata[DATA_W-1:0], s_tdata[TDATA_W-1:DATA_W]);

            pending_results = filtered_q.size();
        end
    end

endmodule

/* sim/tb_scalar_kalman_velocity_filter.sv */
// Testbench top for the velocity Kalman filter: stimulus, back-pressure and the verdict.
module tb_scalar_kalman_velocity_filter;
    import skvf_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 10;
    localparam int SETTLE_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int LONG_HOLD_AFTER  = 120;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 92;

    // Register indexes that map to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = CFG_IDX_W'(3);

    localparam logic [DATA_W-1:0] VEL_MAX   = DATA_W'(S_MAX_L);
    localparam logic [DATA_W-1:0] VEL_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] NOISE_MAX = DATA_W'(U_MAX_L);

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [TDATA_W-1:0]   s_tdata   = '0;   // [23:0] velocity_in, [47:24] curvature_in
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PROCESS_NOISE;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [TDATA_W-1:0]   m_tdata;          // [23:0] velocity_out, [47:24] curvature_out
    logic                 cfg_ready;

    int  fail_count;
    int  pending_results;
    int  results_checked;
    int  beats_sent     = 0;
    int  cfg_writes     = 0;
    int  idle_cycles    = 0;
    int  rx_gap         = 0;
    bit  long_hold_done = 1'b0;
    bit  rx_quiet       = 1'b0;
    bit  tx_quiet       = 1'b0;
    logic [DATA_W-1:0] vel_target = '0;

    always #HALF_PERIOD clk = ~clk;

    scalar_kalman_velocity_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    skvf_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // Output side: random stalls, mostly short, and one long hold-off that backs the
    // block up while the input side keeps offering beats.
    always @(posedge clk)
    begin : rx_side
        int roll;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end
        else if (!long_hold_done && beats_sent >= LONG_HOLD_AFTER)
        begin
            long_hold_done <= 1'b1;
            rx_gap         <= LONG_HOLD_CYCLES;
            m_tready       <= 1'b0;
        end
        else if (rx_gap != 0)
        begin
            rx_gap   <= rx_gap - 1;
            m_tready <= (rx_gap == 1);
        end
        else if (rx_quiet)
            m_tready <= 1'b1;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                rx_gap   <= (roll < 93) ? $urandom_range(0, 3) : $urandom_range(20, 120);
            end
        end
    end

    // Watchdog: ends the run when no channel has moved a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Gap before an input beat: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_quiet || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 4);
        if (roll < 96)
            return $urandom_range(5, 45);
        return $urandom_range(60, 200);
    endfunction

    // Noise value for a random phase, weighted towards the edges of the range.
    function automatic logic [DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return NOISE_MAX;
            2:       return DATA_W'($urandom_range(1, 255));
            3:       return DATA_W'($urandom_range(256, 1 << 17));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Offer one measurement and wait until the block takes it; tvalid stays high.
    task automatic send_measurement(input logic [DATA_W-1:0] vel, input logic [DATA_W-1:0] curv);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {curv, vel};
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    // Mostly a noisy track around a slowly jumping target, plus full-range and extreme values.
    task automatic send_random_measurement();
        int roll;
        logic [DATA_W-1:0] vel;
        logic [DATA_W-1:0] curv;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            if ($urandom_range(0, 15) == 0)
                vel_target = DATA_W'($urandom);
            vel = vel_target + DATA_W'($urandom_range(0, 32767)) - DATA_W'(16384);
        end
        else if (roll < 85)
            vel = DATA_W'($urandom);
        else
        begin
            case ($urandom_range(0, 3))
                0:       vel = VEL_MAX;
                1:       vel = VEL_MIN;
                2:       vel = '0;
                default: vel = '1;
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            curv = $urandom_range(0, 1) ? VEL_MAX : VEL_MIN;
        else
            curv = DATA_W'($urandom);
        send_measurement(vel, curv);
    endtask

    // One register write; cfg_valid is left high for a following write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_writes++;
    endtask

    task automatic set_noise(input logic [DATA_W-1:0] q_val, input logic [DATA_W-1:0] r_val);
        write_register(CFG_PROCESS_NOISE, q_val);
        write_register(CFG_MEASUREMENT_NOISE, r_val);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering beats and wait until every filtered beat is back and the block is idle.
    task automatic drain_filter();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [DATA_W-1:0] q_val;
        logic [DATA_W-1:0] r_val;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and bit patterns with the power-on noise values.
        send_measurement('0, '0);
        send_measurement(VEL_MAX, VEL_MIN);
        send_measurement(VEL_MIN, VEL_MAX);
        send_measurement(VEL_MAX, '1);
        send_measurement('1, '0);
        send_measurement(DATA_W'(1), DATA_W'(1));
        send_measurement(24'h555555, 24'hAAAAAA);
        send_measurement(24'hAAAAAA, 24'h555555);
        drain_filter();

        // Writes to unmapped indexes must leave both noise registers alone.
        write_register(CFG_UNMAPPED_LO, DATA_W'($urandom));
        write_register(CFG_UNMAPPED_HI, DATA_W'($urandom));
        cfg_valid <= 1'b0;
        send_measurement(DATA_W'($urandom), DATA_W'($urandom));
        send_measurement(DATA_W'($urandom), DATA_W'($urandom));
        drain_filter();

        // Full-scale process noise: the predicted variance saturates.
        set_noise(NOISE_MAX, R_RESET);
        send_measurement(VEL_MIN, VEL_MAX);
        send_measurement(VEL_MAX, VEL_MIN);
        drain_filter();

        // No noise at all: the first step takes the full gain and clears the variance,
        // after which the denominator is zero and the estimate holds.
        set_noise('0, '0);
        send_measurement(VEL_MAX, '0);
        send_measurement(VEL_MIN, '1);
        send_measurement('0, VEL_MAX);
        drain_filter();

        // Smallest measurement noise, then largest.
        set_noise('0, DATA_W'(1));
        send_measurement(DATA_W'(12345), '0);
        send_measurement(VEL_MIN, '0);
        drain_filter();
        set_noise(DATA_W'(1), NOISE_MAX);
        send_measurement(VEL_MAX, VEL_MAX);
        send_measurement(VEL_MIN, VEL_MIN);
        drain_filter();

        // Random phases, each under its own noise setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    q_val = Q_RESET;
                    r_val = R_RESET;
                end
                1:
                begin
                    q_val = '0;
                    r_val = DATA_W'(1);
                end
                2:
                begin
                    q_val = NOISE_MAX;
                    r_val = NOISE_MAX;
                end
                3:
                begin
                    q_val = '0;
                    r_val = NOISE_MAX;
                end
                4:
                begin
                    q_val = NOISE_MAX;
                    r_val = DATA_W'(1);
                end
                default:
                begin
                    q_val = pick_noise();
                    r_val = pick_noise();
                end
            endcase
            // One phase runs flat out on both sides.
            tx_quiet = (phase == 5);
            rx_quiet = (phase == 5);
            set_noise(q_val, r_val);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_measurement();
            drain_filter();
        end

        if (pending_results != 0)
            $error("%0d filtered beats never arrived", pending_results);
        $display("Filter run: %0d measurements sent, %0d filtered beats checked, %0d register writes.",
                 beats_sent, results_checked, cfg_writes);
        $display("Noise settings spanned zero, unit, full-scale and random values, with one long hold-off.");
        if (fail_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
